// File: rtl/tilt_angle_kalman_filter_core_macros.svh
// Assertion macros used by the checker file of the tilt Kalman filter.
`ifndef TILT_ANGLE_KALMAN_FILTER_CORE_MACROS_SVH
`define TILT_ANGLE_KALMAN_FILTER_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define TAK_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that holds at every edge, reset included.
`define TAK_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tak_pkg.sv
// Shared types, constants and saturation helpers of the tilt Kalman filter.
package tak_pkg;

    // Fixed-point layout.
    localparam int FRAC_BITS = 24;
    localparam int GAIN_W    = 32;
    localparam int DEN_W     = 33;
    localparam int QUO_W     = 57;

    // Limits and reset values.
    localparam logic signed [43:0] ANGLE_LIMIT = 44'sd23592960;
    localparam logic signed [43:0] BIAS_LIMIT  = 44'sd131072000;
    localparam logic signed [43:0] SAT32_MAX   = 44'sd2147483647;
    localparam logic signed [43:0] SAT32_MIN   = -44'sd2147483648;
    localparam logic signed [31:0] COV_INIT    = 32'sd50331648;

    localparam logic [24:0] STEP_TIME_RST     = 25'd16466;
    localparam logic [27:0] MEASURE_NOISE_RST = 28'd16777216;
    localparam logic [27:0] ANGLE_NOISE_RST   = 28'd16777;
    localparam logic [27:0] BIAS_NOISE_RST    = 28'd50332;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_STEP_TIME     = 2'd0;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd1;
    localparam logic [1:0] REG_ANGLE_NOISE   = 2'd2;
    localparam logic [1:0] REG_BIAS_NOISE    = 2'd3;

    // Request to the gain divider.
    typedef struct packed {
        logic                     start;
        logic signed [GAIN_W-1:0] num;
        logic [DEN_W-1:0]         den;
    } div_req_t;

    // Saturate a wide intermediate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [43:0] x);
        logic signed [43:0] y;
        begin
            y = x;
            if (x > SAT32_MAX) begin
                y = SAT32_MAX;
            end else if (x < SAT32_MIN) begin
                y = SAT32_MIN;
            end
            return y[31:0];
        end
    endfunction

    // Clamp to plus or minus 360 degrees.
    function automatic logic signed [25:0] clamp_angle(input logic signed [43:0] x);
        logic signed [43:0] y;
        begin
            y = x;
            if (x > ANGLE_LIMIT) begin
                y = ANGLE_LIMIT;
            end else if (x < -ANGLE_LIMIT) begin
                y = -ANGLE_LIMIT;
            end
            return y[25:0];
        end
    endfunction

    // Clamp to plus or minus 2000 degrees per second.
    function automatic logic signed [27:0] clamp_bias(input logic signed [43:0] x);
        logic signed [43:0] y;
        begin
            y = x;
            if (x > BIAS_LIMIT) begin
                y = BIAS_LIMIT;
            end else if (x < -BIAS_LIMIT) begin
                y = -BIAS_LIMIT;
            end
            return y[27:0];
        end
    endfunction

endpackage

// File: rtl/tak_div.sv
// Bit-serial restoring divider that forms one Kalman gain, num * 2^24 / den.
module tak_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tak_pkg::div_req_t                 req,
    output logic                              done,
    output logic signed [tak_pkg::GAIN_W-1:0] quo
);

    logic                           busy_reg;
    logic                           done_reg;
    logic                           neg_reg;
    logic [5:0]                     cnt_reg;
    logic [tak_pkg::DEN_W-1:0]      den_reg;
    logic [tak_pkg::DEN_W:0]        rem_reg;
    logic [tak_pkg::QUO_W-1:0]      quo_reg;

    logic [tak_pkg::DEN_W-1:0]      mag;
    logic [tak_pkg::DEN_W:0]        trial;
    logic [tak_pkg::DEN_W:0]        diff;
    logic                           fits;

    // Magnitude of the signed numerator.
    always_comb begin
        if (req.num[tak_pkg::GAIN_W-1]) begin
            mag = -{req.num[tak_pkg::GAIN_W-1], req.num};
        end else begin
            mag = {1'b0, req.num};
        end
    end

    // One quotient bit per cycle.
    assign trial = {rem_reg[tak_pkg::DEN_W-1:0], quo_reg[tak_pkg::QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(tak_pkg::QUO_W - 1);
                neg_reg  <= req.num[tak_pkg::GAIN_W-1];
                den_reg  <= req.den;
                rem_reg  <= '0;
                quo_reg  <= {mag, {tak_pkg::FRAC_BITS{1'b0}}};
            end else if (busy_reg) begin
                rem_reg <= fits ? diff : trial;
                quo_reg <= {quo_reg[tak_pkg::QUO_W-2:0], fits};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    // Apply the sign and saturate to 32 bits.
    always_comb begin
        if (!neg_reg) begin
            if (|quo_reg[tak_pkg::QUO_W-1:tak_pkg::GAIN_W-1]) begin
                quo = 32'sh7FFF_FFFF;
            end else begin
                quo = quo_reg[tak_pkg::GAIN_W-1:0];
            end
        end else begin
            if (quo_reg > {{(tak_pkg::QUO_W-32){1'b0}}, 32'h8000_0000}) begin
                quo = 32'sh8000_0000;
            end else begin
                quo = -quo_reg[tak_pkg::GAIN_W-1:0];
            end
        end
    end

    assign done = done_reg;

endmodule

// File: rtl/tilt_angle_kalman_filter_core.sv
// Top level of the two-state tilt Kalman filter with its sequencer and shared multiplier.
//
// Usage: each word on the s_ channel carries one gyro rate and one accelerometer
// tilt angle (Q9.16). The block runs one predict and correct step of an angle
// and gyro-bias Kalman filter and returns one word on the m_ channel with the
// saturated angle estimate and the bias estimate.
// Data path: ten products share one registered 33x33 multiplier, and the two
// gains come from one bit-serial divider. A new word is taken only after the
// result of the previous one has been loaded into the output register; when
// the innovation variance is not positive the division is skipped. s_tready
// is high only while the sequencer is idle, so one item is in work at a time.
// The result word sits in an output register: the next item is accepted while
// it still waits, and the sequencer holds its next result until the receiver
// has taken the previous one.
// Reset (aresetn low, synchronous) clears the state estimate, sets both
// variances to 3.0 and loads the register defaults; no word is pending after it.
// Registers on the APB port: 0x0 step_time, 0x4 measure_noise,
// 0x8 angle_noise, 0xC bias_noise. Write them only while the block is idle.
module tilt_angle_kalman_filter_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [27:0] rate_sample, [52:28] tilt_measure, zero pad
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [25:0] angle_estimate, [53:26] bias_estimate, zero pad
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_GAIN_S, ST_DIV_K0, ST_WAIT_K0, ST_WAIT_K1, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_RATE, OP_BA, OP_BB, OP_AP01, OP_K0_INN, OP_K1_INN,
        OP_K0_P00, OP_K0_P01, OP_K1_P00, OP_K1_P01
    } op_t;

    state_t state_reg;
    op_t    op_reg;
    logic [1:0] sub_reg;

    logic [24:0] step_time_reg;
    logic [27:0] meas_noise_reg;
    logic [27:0] ang_noise_reg;
    logic [27:0] bias_noise_reg;

    logic signed [25:0] angle_reg;
    logic signed [27:0] bias_reg;
    logic signed [31:0] cov_aa_reg, cov_ab_reg, cov_ba_reg, cov_bb_reg;

    logic signed [27:0] rate_reg;
    logic signed [24:0] tilt_reg;
    logic signed [25:0] ang_p_reg;
    logic signed [31:0] ap00_reg, p01_reg, p00_reg, p10_reg, p11_reg;
    logic signed [32:0] s_reg;
    logic signed [31:0] k0_reg, k1_reg;

    logic signed [32:0] mul_a_reg, mul_b_reg;
    logic signed [65:0] prod_reg;

    logic               m_tvalid_reg;
    logic signed [25:0] out_angle_reg;
    logic signed [27:0] out_bias_reg;

    logic signed [32:0] op_a, op_b;
    logic signed [32:0] dt_ext;
    logic signed [32:0] innov;
    logic signed [65:0] rnd_sum;
    logic signed [43:0] r44;

    tak_pkg::div_req_t                 div_req;
    logic                              div_done;
    logic signed [tak_pkg::GAIN_W-1:0] div_quo;

    logic cfg_wr;

    // Operand selection for the shared multiplier.
    assign dt_ext = {8'd0, step_time_reg};
    assign innov  = 33'(tilt_reg) - 33'(ang_p_reg);

    always_comb begin
        unique case (op_reg)
            OP_RATE: begin
                op_a = dt_ext;
                op_b = 33'(rate_reg) - 33'(bias_reg);
            end
            OP_BA: begin
                op_a = dt_ext;
                op_b = 33'(cov_ba_reg);
            end
            OP_BB: begin
                op_a = dt_ext;
                op_b = 33'(cov_bb_reg);
            end
            OP_AP01: begin
                op_a = dt_ext;
                op_b = 33'(p01_reg);
            end
            OP_K0_INN: begin
                op_a = 33'(k0_reg);
                op_b = innov;
            end
            OP_K1_INN: begin
                op_a = 33'(k1_reg);
                op_b = innov;
            end
            OP_K0_P00: begin
                op_a = 33'(k0_reg);
                op_b = 33'(p00_reg);
            end
            OP_K0_P01: begin
                op_a = 33'(k0_reg);
                op_b = 33'(p01_reg);
            end
            OP_K1_P00: begin
                op_a = 33'(k1_reg);
                op_b = 33'(p00_reg);
            end
            OP_K1_P01: begin
                op_a = 33'(k1_reg);
                op_b = 33'(p01_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Registered product, then round half up at bit 24.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a_reg * mul_b_reg;
    end

    assign rnd_sum = prod_reg + 66'sd8388608;
    assign r44     = 44'($signed(rnd_sum[65:tak_pkg::FRAC_BITS]));

    // Gain divider requests.
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = p00_reg;
        div_req.den   = s_reg;
        if (state_reg == ST_DIV_K0 && s_reg > 33'sd0) begin
            div_req.start = 1'b1;
        end else if (state_reg == ST_WAIT_K0 && div_done) begin
            div_req.start = 1'b1;
            div_req.num   = p10_reg;
        end
    end

    tak_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign cfg_wr = psel && penable && pwrite && pready;

    // Sequencer, filter state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_RATE;
            sub_reg        <= 2'd0;
            m_tvalid_reg   <= 1'b0;
            step_time_reg  <= tak_pkg::STEP_TIME_RST;
            meas_noise_reg <= tak_pkg::MEASURE_NOISE_RST;
            ang_noise_reg  <= tak_pkg::ANGLE_NOISE_RST;
            bias_noise_reg <= tak_pkg::BIAS_NOISE_RST;
            angle_reg      <= '0;
            bias_reg       <= '0;
            cov_aa_reg     <= tak_pkg::COV_INIT;
            cov_ab_reg     <= '0;
            cov_ba_reg     <= '0;
            cov_bb_reg     <= tak_pkg::COV_INIT;
        end else begin
            // Register writes.
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    tak_pkg::REG_STEP_TIME:     step_time_reg  <= pwdata[24:0];
                    tak_pkg::REG_MEASURE_NOISE: meas_noise_reg <= pwdata[27:0];
                    tak_pkg::REG_ANGLE_NOISE:   ang_noise_reg  <= pwdata[27:0];
                    tak_pkg::REG_BIAS_NOISE:    bias_noise_reg <= pwdata[27:0];
                    default: ;
                endcase
            end

            // A taken word frees the output register unless a new one is loaded.
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        rate_reg  <= s_tdata[27:0];
                        tilt_reg  <= s_tdata[52:28];
                        op_reg    <= OP_RATE;
                        sub_reg   <= 2'd0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (sub_reg == 2'd0) begin
                        mul_a_reg <= op_a;
                        mul_b_reg <= op_b;
                        sub_reg   <= 2'd1;
                    end else if (sub_reg == 2'd1) begin
                        sub_reg <= 2'd2;
                    end else begin
                        sub_reg <= 2'd0;
                        unique case (op_reg)
                            OP_RATE: begin
                                ang_p_reg <= tak_pkg::clamp_angle(44'(angle_reg) + r44);
                                op_reg    <= OP_BA;
                            end
                            OP_BA: begin
                                ap00_reg <= tak_pkg::sat32(44'(cov_aa_reg) - r44);
                                op_reg   <= OP_BB;
                            end
                            OP_BB: begin
                                p01_reg <= tak_pkg::sat32(44'(cov_ab_reg) - r44);
                                p10_reg <= tak_pkg::sat32(44'(cov_ba_reg) - r44);
                                op_reg  <= OP_AP01;
                            end
                            OP_AP01: begin
                                p00_reg <= tak_pkg::sat32(44'(ap00_reg) - r44
                                                          + 44'(ang_noise_reg));
                                p11_reg <= tak_pkg::sat32(44'(cov_bb_reg)
                                                          + 44'(bias_noise_reg));
                                state_reg <= ST_GAIN_S;
                            end
                            OP_K0_INN: begin
                                angle_reg <= tak_pkg::clamp_angle(44'(ang_p_reg) + r44);
                                op_reg    <= OP_K1_INN;
                            end
                            OP_K1_INN: begin
                                bias_reg <= tak_pkg::clamp_bias(44'(bias_reg) + r44);
                                op_reg   <= OP_K0_P00;
                            end
                            OP_K0_P00: begin
                                cov_aa_reg <= tak_pkg::sat32(44'(p00_reg) - r44);
                                op_reg     <= OP_K0_P01;
                            end
                            OP_K0_P01: begin
                                cov_ab_reg <= tak_pkg::sat32(44'(p01_reg) - r44);
                                op_reg     <= OP_K1_P00;
                            end
                            OP_K1_P00: begin
                                cov_ba_reg <= tak_pkg::sat32(44'(p10_reg) - r44);
                                op_reg     <= OP_K1_P01;
                            end
                            OP_K1_P01: begin
                                cov_bb_reg <= tak_pkg::sat32(44'(p11_reg) - r44);
                                state_reg  <= ST_OUT;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_GAIN_S: begin
                    s_reg     <= 33'(p00_reg) + 33'(meas_noise_reg);
                    state_reg <= ST_DIV_K0;
                end
                ST_DIV_K0: begin
                    if (s_reg > 33'sd0) begin
                        state_reg <= ST_WAIT_K0;
                    end else begin
                        // Variance not positive: no correction at all.
                        k0_reg    <= '0;
                        k1_reg    <= '0;
                        op_reg    <= OP_K0_INN;
                        sub_reg   <= 2'd0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_WAIT_K0: begin
                    if (div_done) begin
                        k0_reg    <= div_quo;
                        state_reg <= ST_WAIT_K1;
                    end
                end
                ST_WAIT_K1: begin
                    if (div_done) begin
                        k1_reg    <= div_quo;
                        op_reg    <= OP_K0_INN;
                        sub_reg   <= 2'd0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        out_angle_reg <= angle_reg;
                        out_bias_reg  <= bias_reg;
                        m_tvalid_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            tak_pkg::REG_STEP_TIME:     prdata = {7'd0, step_time_reg};
            tak_pkg::REG_MEASURE_NOISE: prdata = {4'd0, meas_noise_reg};
            tak_pkg::REG_ANGLE_NOISE:   prdata = {4'd0, ang_noise_reg};
            tak_pkg::REG_BIAS_NOISE:    prdata = {4'd0, bias_noise_reg};
            default:                    prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'd0, out_bias_reg, out_angle_reg};

endmodule

// File: rtl/tak_checker.sv
// Port-level checker of the tilt Kalman filter and its bind to the top level.
`include "tilt_angle_kalman_filter_core_macros.svh"

module tak_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        pready
);

    // A stalled result word holds.
    `TAK_ASSERT_RST(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // One item at a time: the sequencer is busy right after an acceptance.
    `TAK_ASSERT_RST(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input accepted while an item was in work")

    // The angle estimate stays within plus or minus 360 degrees.
    `TAK_ASSERT_RST(a_angle_range, aclk, aresetn, m_tvalid |-> ($signed(m_tdata[25:0]) >= -26'sd23592960) && ($signed(m_tdata[25:0]) <= 26'sd23592960), "angle estimate out of range")

    // The configuration port never waits.
    `TAK_ASSERT_ALL(a_pready_high, aclk, pready, "pready dropped")

endmodule

bind tilt_angle_kalman_filter_core tak_checker u_tak_checker (.*);

// File: tb/sv/tb_tilt_angle_kalman_filter_core.sv
// Self-checking testbench of the two-state tilt Kalman filter core.
module tb_tilt_angle_kalman_filter_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  ITEMS_PER_PHASE = 108;
    localparam int  SETTLE_CYCLES   = 200;
    localparam int  LONG_HOLD       = 800;
    localparam longint A_LIM        = 23592960;
    localparam longint B_LIM        = 131072000;
    localparam longint I32_MAX      = 64'sd2147483647;
    localparam longint I32_MIN      = -64'sd2147483648;

    typedef struct packed {
        logic [27:0] bias;
        logic [25:0] angle;
    } estimate_t;

    typedef struct {
        logic [27:0] rate;
        logic [24:0] tilt;
        bit          typed;
        estimate_t   known;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Mirror of the filter state and its registers.
    longint dt_reg, meas_var, ang_var_q, bias_var_q;
    longint angle_acc, bias_acc, p_aa, p_ab, p_ba, p_bb;

    estimate_t estimates_due[$];
    int        mismatches;
    int        words_sent;
    int        words_checked;
    int        hold_asked;
    int        hold_taken;
    int        rx_wait;
    bit        rx_burst;
    bit        tx_burst;

    tilt_angle_kalman_filter_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Overall time limit.
    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // Q8.24 product rounding: add a half and floor.
    function automatic longint round_q24(input longint x);
        return (x + (64'sd1 <<< 23)) >>> 24;
    endfunction

    function automatic longint gain_q24(input longint num, input longint den);
        if (den <= 0) return 0;
        return clip((num <<< 24) / den, I32_MIN, I32_MAX);
    endfunction

    // One predict and correct step; updates the mirrored state.
    function automatic estimate_t kalman_step(input logic [27:0] rate_raw,
                                              input logic [24:0] tilt_raw);
        longint rate, tilt, ang_p, ap00, ap01, p00, p01, p10, p11, innov, den, k0, k1;
        estimate_t est;
        rate  = longint'($signed(rate_raw));
        tilt  = longint'($signed(tilt_raw));
        ang_p = clip(angle_acc + round_q24(dt_reg * (rate - bias_acc)), -A_LIM, A_LIM);
        ap00  = clip(p_aa - round_q24(dt_reg * p_ba), I32_MIN, I32_MAX);
        ap01  = clip(p_ab - round_q24(dt_reg * p_bb), I32_MIN, I32_MAX);
        p00   = clip(ap00 - round_q24(dt_reg * ap01) + ang_var_q, I32_MIN, I32_MAX);
        p01   = ap01;
        p10   = clip(p_ba - round_q24(dt_reg * p_bb), I32_MIN, I32_MAX);
        p11   = clip(p_bb + bias_var_q, I32_MIN, I32_MAX);
        innov = tilt - ang_p;
        den   = p00 + meas_var;
        k0    = gain_q24(p00, den);
        k1    = gain_q24(p10, den);
        angle_acc = clip(ang_p + round_q24(k0 * innov), -A_LIM, A_LIM);
        bias_acc  = clip(bias_acc + round_q24(k1 * innov), -B_LIM, B_LIM);
        p_aa = clip(p00 - round_q24(k0 * p00), I32_MIN, I32_MAX);
        p_ab = clip(p01 - round_q24(k0 * p01), I32_MIN, I32_MAX);
        p_ba = clip(p10 - round_q24(k1 * p00), I32_MIN, I32_MAX);
        p_bb = clip(p11 - round_q24(k1 * p01), I32_MIN, I32_MAX);
        est.angle = angle_acc[25:0];
        est.bias  = bias_acc[27:0];
        return est;
    endfunction

    function automatic void note_mismatch(input string what, input longint want,
                                          input longint got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
        end
    endfunction

    // Register write followed by a read-back, on the APB port.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        longint masked;
        masked = (idx == tak_pkg::REG_STEP_TIME) ? longint'(value[24:0])
                                                 : longint'(value[27:0]);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (longint'(prdata) != masked) begin
            note_mismatch("register read-back", masked, longint'(prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            tak_pkg::REG_STEP_TIME:     dt_reg     = masked;
            tak_pkg::REG_MEASURE_NOISE: meas_var   = masked;
            tak_pkg::REG_ANGLE_NOISE:   ang_var_q  = masked;
            default:                    bias_var_q = masked;
        endcase
    endtask

    task automatic set_config(input logic [31:0] dt_v, input logic [31:0] r_v,
                              input logic [31:0] qa_v, input logic [31:0] qb_v);
        write_reg(tak_pkg::REG_STEP_TIME, dt_v);
        write_reg(tak_pkg::REG_MEASURE_NOISE, r_v);
        write_reg(tak_pkg::REG_ANGLE_NOISE, qa_v);
        write_reg(tak_pkg::REG_BIAS_NOISE, qb_v);
    endtask

    // Offer one word, wait for it to be taken, then draw the gap to the next.
    task automatic send_word(input logic [27:0] rate, input logic [24:0] tilt,
                             input bit typed, input estimate_t known);
        estimate_t est;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, tilt, rate};
        do @(posedge aclk); while (!s_tready);
        est = kalman_step(rate, tilt);
        if (typed && est != known) begin
            note_mismatch("typed angle", longint'($signed(known.angle)),
                          longint'($signed(est.angle)));
        end
        estimates_due.push_back(typed ? known : est);
        words_sent++;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (estimates_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random_word();
        logic [27:0] rate;
        logic [24:0] tilt;
        int pick;
        estimate_t none;
        none = '0;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            rate = 28'($urandom());
            tilt = 25'($urandom());
        end else if (pick < 4) begin
            // Steady platform: small rate, tilt close to the estimate.
            rate = 28'($signed($urandom_range(0, 2000000)) - 1000000);
            tilt = 25'(angle_acc + $signed($urandom_range(0, 600000)) - 300000);
        end else begin
            rate = 28'(longint'($urandom_range(0, 262144000)) - B_LIM);
            tilt = 25'(longint'($urandom_range(0, 23592960)) - 11796480);
        end
        send_word(rate, tilt, 1'b0, none);
    endtask

    // Result side: checks each taken word and draws its own stalls.
    always @(posedge aclk) begin
        estimate_t want;
        estimate_t got;
        int w;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            rx_wait    <= 0;
            hold_taken <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[53:0];
                words_checked++;
                if (estimates_due.size() == 0) begin
                    note_mismatch("unexpected word", 0, longint'($signed(got.angle)));
                end else begin
                    want = estimates_due.pop_front();
                    if (got.angle != want.angle) begin
                        note_mismatch("angle_estimate", longint'($signed(want.angle)),
                                      longint'($signed(got.angle)));
                    end
                    if (got.bias != want.bias) begin
                        note_mismatch("bias_estimate", longint'($signed(want.bias)),
                                      longint'($signed(got.bias)));
                    end
                end
            end
            if (hold_taken != hold_asked) begin
                hold_taken <= hold_asked;
                rx_wait    <= LONG_HOLD;
                m_tready   <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait  <= rx_wait - 1;
                m_tready <= (rx_wait == 1);
            end else if (m_tvalid && m_tready) begin
                w = rx_burst ? 0 : $urandom_range(0, 13);
                rx_wait  <= w;
                m_tready <= (w == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus.
    initial begin
        stim_row_t rows[$];
        estimate_t none;
        int phase;
        none = '0;
        aresetn = 1'b0;  s_tvalid = 1'b0;  s_tdata = '0;
        psel = 1'b0;  penable = 1'b0;  pwrite = 1'b0;  paddr = '0;  pwdata = '0;
        mismatches = 0;  words_sent = 0;  words_checked = 0;
        hold_asked = 0;  rx_burst = 1'b0;  tx_burst = 1'b0;
        dt_reg = 16466;  meas_var = 16777216;  ang_var_q = 16777;  bias_var_q = 50332;
        angle_acc = 0;  bias_acc = 0;  p_aa = 50331648;  p_ab = 0;  p_ba = 0;
        p_bb = 50331648;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: a level start from reset gives a zero estimate.
        rows.push_back('{28'd0, 25'd0, 1'b1, '0});
        rows.push_back('{28'd131072000, 25'd11796480, 1'b0, '0});
        rows.push_back('{-28'sd131072000, -25'sd11796480, 1'b0, '0});
        rows.push_back('{28'h7FF_FFFF, 25'h0FF_FFFF, 1'b0, '0});
        rows.push_back('{28'h800_0000, 25'h100_0000, 1'b0, '0});
        rows.push_back('{28'hFFF_FFFF, 25'h1FF_FFFF, 1'b0, '0});
        rows.push_back('{28'd0, 25'd11796480, 1'b0, '0});
        rows.push_back('{28'd131072000, 25'h0FF_FFFF, 1'b0, '0});
        rows.push_back('{28'd0, 25'd0, 1'b0, '0});
        foreach (rows[i]) send_word(rows[i].rate, rows[i].tilt, rows[i].typed, rows[i].known);
        wait_drained();

        // Extreme settings: a one-second step drives the angle into saturation.
        set_config(32'd16777216, 32'd1, 32'd0, 32'd0);
        for (int i = 0; i < 6; i++) send_word(28'd131072000, 25'd11796480, 1'b0, none);
        for (int i = 0; i < 6; i++) send_word(-28'sd131072000, -25'sd11796480, 1'b0, none);
        wait_drained();
        set_config(32'd1, 32'd268435455, 32'd268435455, 32'd268435455);
        for (int i = 0; i < 4; i++) send_word(28'h7FF_FFFF, 25'h100_0000, 1'b0, none);
        wait_drained();

        // Random phases, each with its own setting and handshake pressure.
        for (phase = 0; phase < 6; phase++) begin
            if (phase == 1) begin
                set_config(32'd16466, 32'd16777216, 32'd16777, 32'd50332);
            end else if (phase == 2) begin
                set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            end else begin
                set_config($urandom_range(1, 1000000), $urandom_range(1, 268435455),
                           $urandom_range(0, 268435455) >> $urandom_range(0, 20),
                           $urandom_range(0, 268435455) >> $urandom_range(0, 20));
            end
            tx_burst = (phase == 3);
            rx_burst = (phase == 3) || (phase == 4);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (phase == 1 && i == 10) hold_asked <= hold_asked + 1;
                if (phase == 2 && i == ITEMS_PER_PHASE / 2) begin
                    s_tvalid <= 1'b0;
                    while (estimates_due.size() != 0) @(posedge aclk);
                end
                send_random_word();
            end
            wait_drained();
        end

        $display("Sent %0d words over reset, extreme and random settings; checked %0d.",
                 words_sent, words_checked);
        $display("Receiver stalls, a long hold-off and a drained pause were exercised.");
        if (mismatches == 0 && estimates_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d words outstanding", mismatches,
                     estimates_due.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
